/* hw/rtl/modbus_rtu_frame_receiver_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the Modbus RTU receiver RTL.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define MODBUS_RTU_FRAME_RECEIVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define MBRX_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Condition must never be true outside reset.
`define MBRX_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define MBRX_ASSERT(lbl, clk, rst_n, prop)
`define MBRX_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* hw/rtl/mbrx_pkg.sv */
// ----------------------------------------------------------------------------
// mbrx_pkg
// Types, codes and the CRC-16 byte fold for the Modbus RTU receiver.
// ----------------------------------------------------------------------------
package mbrx_pkg;

    // Input operation codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // End-of-frame status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TIMEOUT = 3'd1;
    localparam logic [2:0] ST_OVERRUN = 3'd2;
    localparam logic [2:0] ST_SHORT   = 3'd3;
    localparam logic [2:0] ST_CRC     = 3'd4;

    // Configuration register indexes
    localparam logic CFG_FIRST_TIMEOUT = 1'b0;
    localparam logic CFG_GAP_TIMEOUT   = 1'b1;

    localparam logic [7:0]  FIRST_TIMEOUT_RST = 8'd100;
    localparam logic [7:0]  GAP_TIMEOUT_RST   = 8'd20;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam int unsigned MIN_FRAME         = 4;

    // Output buffer depth; at least two free entries are needed to take a word
    localparam int unsigned OBUF_DEPTH = 4;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] in_byte;
    } t_in_word;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [2:0] status;
        logic [4:0] frame_length;
        logic       last;
    } t_out_word;

    // Results produced by one accepted input word
    typedef struct packed {
        logic [1:0] cnt;
        t_out_word  w0;
        t_out_word  w1;
    } t_push;

    // Reflected CRC-16, one byte folded in
    function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

/* hw/rtl/mbrx_ctrl.sv */
// ----------------------------------------------------------------------------
// mbrx_ctrl
// Receiver state, timeout registers and result generation.
// ----------------------------------------------------------------------------
module mbrx_ctrl
    import mbrx_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_word i_word,
    input  logic     i_cfg_we,
    input  logic     i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output t_push    o_push,
    output logic     o_armed
);

    localparam int unsigned CW = $clog2(MAX_FRAME);
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_FRAME - 1);

    logic [7:0]    r_first_to;
    logic [7:0]    r_gap_to;
    logic          r_armed,  n_armed;
    logic [CW-1:0] r_count,  n_count;
    logic [7:0]    r_timer,  n_timer;
    logic [15:0]   r_crc,    n_crc;
    logic [7:0]    w_tdec;
    logic [4:0]    w_len;

    assign w_tdec = (r_timer == 8'd0) ? 8'd0 : r_timer - 8'd1;
    assign w_len  = 5'(r_count - CW'(2));

    always_comb begin
        n_armed = r_armed;
        n_count = r_count;
        n_timer = r_timer;
        n_crc   = r_crc;
        o_push  = '0;
        if (i_accept) begin
            case (i_word.op)
                OP_START: begin
                    n_armed = 1'b1;
                    n_count = '0;
                    n_crc   = CRC_INIT;
                    n_timer = r_first_to;
                end
                OP_BYTE: begin
                    if (r_armed) begin
                        n_crc   = crc_fold(r_crc, i_word.in_byte);
                        n_timer = r_gap_to;
                        n_count = r_count + CW'(1);
                        o_push.w0.kind     = KIND_DATA;
                        o_push.w0.out_byte = i_word.in_byte;
                        if (r_count == LAST_IDX) begin
                            // overrun: data word then status word
                            n_armed = 1'b0;
                            o_push.cnt       = 2'd2;
                            o_push.w1.kind   = KIND_STATUS;
                            o_push.w1.status = ST_OVERRUN;
                            o_push.w1.last   = 1'b1;
                        end else begin
                            o_push.cnt     = 2'd1;
                            o_push.w0.last = 1'b1;
                        end
                    end
                end
                OP_TICK: begin
                    if (r_armed) begin
                        n_timer = w_tdec;
                        if (w_tdec == 8'd0) begin
                            n_armed        = 1'b0;
                            o_push.cnt     = 2'd1;
                            o_push.w0.kind = KIND_STATUS;
                            o_push.w0.last = 1'b1;
                            if (r_count == '0) begin
                                o_push.w0.status = ST_TIMEOUT;
                            end else if (r_count < CW'(MIN_FRAME)) begin
                                o_push.w0.status = ST_SHORT;
                            end else if (r_crc != 16'd0) begin
                                o_push.w0.status = ST_CRC;
                            end else begin
                                o_push.w0.status       = ST_OK;
                                o_push.w0.frame_length = w_len;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_to <= FIRST_TIMEOUT_RST;
            r_gap_to   <= GAP_TIMEOUT_RST;
            r_armed    <= 1'b0;
            r_count    <= '0;
            r_timer    <= 8'd0;
            r_crc      <= CRC_INIT;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FIRST_TIMEOUT) begin
                    r_first_to <= i_cfg_data;
                end else begin
                    r_gap_to <= i_cfg_data;
                end
            end
            r_armed <= n_armed;
            r_count <= n_count;
            r_timer <= n_timer;
            r_crc   <= n_crc;
        end
    end

    assign o_armed = r_armed;

endmodule

/* hw/rtl/mbrx_obuf.sv */
// ----------------------------------------------------------------------------
// mbrx_obuf
// Small result queue: takes up to two words per cycle, gives one per cycle while the consumer is ready.
// ----------------------------------------------------------------------------
module mbrx_obuf
    import mbrx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output logic      o_space,
    output logic [$clog2(OBUF_DEPTH+1)-1:0] o_level,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    localparam int unsigned PW = $clog2(OBUF_DEPTH);
    localparam int unsigned LW = $clog2(OBUF_DEPTH + 1);

    t_out_word         r_mem [OBUF_DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [LW-1:0]     r_level;
    logic              w_pop;

    assign w_pop   = (r_level != '0) && i_ready;
    assign o_valid = (r_level != '0);
    assign o_word  = r_mem[r_rd];
    assign o_space = (r_level <= LW'(OBUF_DEPTH - 2));
    assign o_level = r_level;

    // payload entries, no reset
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.w0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + PW'(1)] <= i_push.w1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= r_wr + PW'(i_push.cnt);
            r_rd    <= r_rd + PW'(w_pop);
            r_level <= r_level + LW'(i_push.cnt) - LW'(w_pop);
        end
    end

endmodule

/* hw/rtl/modbus_rtu_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver_unit
// Modbus RTU response receiver with CRC-16 check and silence timeout.
// ----------------------------------------------------------------------------
// Feed one word per cycle: start (arm, load first-byte timeout), byte (pass
// the byte on as a data word, fold it into the reflected CRC-16, reload the
// gap timeout) or tick (count the timer down; at zero, report timeout, frame
// too short, CRC error or ok with the payload length). Each input word is
// decoded in the cycle it is accepted and its results land in a four-entry
// registered result queue that hands them to the output in order. A new
// input word can be taken every cycle while ready is high; the input side
// drops ready only while fewer than two queue entries are free, which happens
// only when the consumer stalls. The extra overrun status word that follows
// the data word of the MAX_FRAME-th byte is absorbed by the queue without a
// stall when the consumer takes a word every cycle. Timeout registers are
// written through the config channel, which is always ready; a new value
// applies at the next timer load. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "modbus_rtu_frame_receiver_unit_defines.svh"

module modbus_rtu_frame_receiver_unit
    import mbrx_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input words
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_word,
    // result words
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_word,
    // configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int unsigned LW = $clog2(OBUF_DEPTH + 1);

    logic          w_accept;
    t_push         w_push;
    logic          w_armed;
    logic          w_space;
    logic [LW-1:0] w_level;

    // take an input word only when the queue can hold two results
    assign o_in_ready  = w_space;
    assign w_accept    = i_in_valid && w_space;
    assign o_cfg_ready = 1'b1;

    mbrx_ctrl #(
        .MAX_FRAME (MAX_FRAME)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_word      (i_in_word),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (w_push),
        .o_armed     (w_armed)
    );

    mbrx_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_space (w_space),
        .o_level (w_level),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

    // queue must never be pushed beyond its free space
    `MBRX_NEVER(a_no_overflow, i_clk, i_rst_n, (w_level + LW'(w_push.cnt)) > LW'(OBUF_DEPTH))
    // a status word always returns the receiver to idle
    `MBRX_ASSERT(a_status_idles, i_clk, i_rst_n, ((w_push.cnt == 2'd1) && (w_push.w0.kind == KIND_STATUS)) |=> !w_armed)
    // a double push is always data then overrun status
    `MBRX_ASSERT(a_overrun_pair, i_clk, i_rst_n, (w_push.cnt == 2'd2) |-> ((w_push.w0.kind == KIND_DATA) && !w_push.w0.last && (w_push.w1.status == ST_OVERRUN) && w_push.w1.last))

endmodule
